// ===== hw/rtl/pulse_output_sequencer_assert.svh =====
// Assertion macros for the pulse output sequencer port-level checker.
`ifndef PULSE_OUTPUT_SEQUENCER_ASSERT_SVH
`define PULSE_OUTPUT_SEQUENCER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define POS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pulse_output_sequencer assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define POS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pulse_output_sequencer assertion failed");

`endif

// ===== hw/rtl/pos_pkg.sv =====
// Shared types and constants for the pulse output sequencer.
`timescale 1ns / 1ps

package pos_pkg;

  // Input opcodes carried on tuser
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_REQUEST = 2'd1;
  localparam logic [1:0] OP_SENSE   = 2'd2;
  localparam logic [1:0] OP_LEVEL   = 2'd3;

  // Sequencer phase codes
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_WAIT  = 3'd1;
  localparam logic [2:0] PH_START = 3'd2;
  localparam logic [2:0] PH_ARM   = 3'd3;
  localparam logic [2:0] PH_HIGH  = 3'd4;
  localparam logic [2:0] PH_LOW   = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;
  localparam logic [2:0] PH_END   = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_ON_TIME        = 2'd0;
  localparam logic [1:0] REG_INVERT         = 2'd1;
  localparam logic [1:0] REG_OUTPUT_PRESENT = 2'd2;

  localparam int OPCODE_W    = 2;
  localparam int DELAY_W     = 16;
  localparam int ON_TIME_W   = 16;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 8;

  // Input tdata bit positions
  localparam int IN_LEVEL_BIT = 16;
  localparam int IN_SENSE_BIT = 17;

  // Output tdata bit positions
  localparam int OUT_PIN_BIT   = 0;
  localparam int OUT_STATE_BIT = 1;
  localparam int OUT_ON_BIT    = 2;
  localparam int OUT_OFF_BIT   = 3;

endpackage

// ===== hw/rtl/pulse_output_sequencer.sv =====
// Pulse output sequencer: one-pin pulse and sense-cycle controller.
`timescale 1ns / 1ps

// Each transfer on the slave side is one command: a millisecond tick, a pulse
// request, a sense-cycle start or a direct level write, selected by tuser.
// Every command produces exactly one result transfer on the master side with
// the pin level, the logical state and the on/off event flags of that step.
// The block takes one command per clock while m_tready is high: a command sits in
// the input register, the sequencer update and result are computed from it and
// written to the result register when it advances, and the result transfers
// from there; throughput is one item per cycle while m_tready is high.
// The result register holds a finished result while the next command is
// taken; the input side stalls only when both registers are full and
// m_tready is low. Configure on_time, invert and output_present through the
// write port while no command is in flight. TIME_BITS sets the width of the
// saturating tick timer.
module pulse_output_sequencer #(
  parameter int TIME_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write port
  input  logic                              cfg_wr,
  input  logic [pos_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pos_pkg::CFG_DATA_W-1:0]    cfg_data,
  // Command stream
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [15:0] sense_delay, [16] level, [17] sense_level, [23:18] zero
  input  logic [pos_pkg::IN_TDATA_W-1:0]    s_tdata,
  // [1:0] opcode
  input  logic [pos_pkg::OPCODE_W-1:0]      s_tuser,
  // Result stream
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [0] pin_level, [1] state_flag, [2] on_event, [3] off_event, [7:4] zero
  output logic [pos_pkg::OUT_TDATA_W-1:0]   m_tdata
);

  localparam int CW = (TIME_BITS > pos_pkg::ON_TIME_W) ? TIME_BITS : pos_pkg::ON_TIME_W;
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  // Timer compare: duration saturates to the timer's maximum.
  function automatic logic timed_out(input logic [TIME_BITS-1:0]         el,
                                     input logic [pos_pkg::ON_TIME_W-1:0] dur);
    logic [CW-1:0] d;
    logic [CW-1:0] m;
    d = CW'(dur);
    m = CW'(TMAX);
    if (d > m) d = m;
    return CW'(el) >= d;
  endfunction

  // Configuration registers
  logic [pos_pkg::ON_TIME_W-1:0] on_time;
  logic                          invert;
  logic                          output_present;

  // Input register
  logic                          in_valid;
  logic [pos_pkg::OPCODE_W-1:0]  in_op;
  logic [pos_pkg::DELAY_W-1:0]   in_delay;
  logic                          in_level;
  logic                          in_sense;

  // Sequencer state
  logic [2:0]                    phase;
  logic                          request_latch;
  logic                          sense_mode;
  logic [pos_pkg::DELAY_W-1:0]   sense_hold;
  logic [TIME_BITS-1:0]          elapsed;
  logic                          drive_level;
  logic                          logical_state;

  logic [2:0]                    phase_next;
  logic                          request_latch_next;
  logic                          sense_mode_next;
  logic [pos_pkg::DELAY_W-1:0]   sense_hold_next;
  logic [TIME_BITS-1:0]          elapsed_next;
  logic                          drive_level_next;
  logic                          logical_state_next;
  logic                          on_event_next;
  logic                          off_event_next;

  // Result register
  logic                          out_valid;
  logic [pos_pkg::OUT_TDATA_W-1:0] out_data;
  logic [pos_pkg::OUT_TDATA_W-1:0] result_word;

  logic advance;
  logic stop;

  // Move the input item on whenever the result register is free or draining.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

  // Configuration writes; writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      on_time        <= '0;
      invert         <= 1'b0;
      output_present <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_index)
        pos_pkg::REG_ON_TIME:        on_time        <= cfg_data;
        pos_pkg::REG_INVERT:         invert         <= cfg_data[0];
        pos_pkg::REG_OUTPUT_PRESENT: output_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Input register: hold the command until it advances.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op    <= s_tuser;
      in_delay <= s_tdata[pos_pkg::DELAY_W-1:0];
      in_level <= s_tdata[pos_pkg::IN_LEVEL_BIT];
      in_sense <= s_tdata[pos_pkg::IN_SENSE_BIT];
    end
  end

  // One step of the sequencer, written as the ordered chain of phase checks
  // that a single tick walks through. A drive only lands when a pin exists.
  always_comb begin
    phase_next         = phase;
    request_latch_next = request_latch;
    sense_mode_next    = sense_mode;
    sense_hold_next    = sense_hold;
    elapsed_next       = elapsed;
    drive_level_next   = drive_level;
    logical_state_next = logical_state;
    on_event_next      = 1'b0;
    off_event_next     = 1'b0;
    stop               = 1'b0;

    case (in_op)
      pos_pkg::OP_TICK: begin
        // Advance the saturating timer before the phase logic looks at it.
        if (elapsed_next != TMAX) elapsed_next = elapsed_next + TIME_BITS'(1);

        if (sense_mode) begin
          // Sense cycle: drive on, wait for sense low then high, hold, drive off.
          if (phase_next == pos_pkg::PH_END) begin
            request_latch_next = 1'b0;
            logical_state_next = 1'b0;
            phase_next         = pos_pkg::PH_IDLE;
          end
          if (phase_next == pos_pkg::PH_IDLE) phase_next = pos_pkg::PH_WAIT;
          if (phase_next > pos_pkg::PH_WAIT && !request_latch_next) begin
            phase_next = pos_pkg::PH_END;
            stop       = 1'b1;
          end
          if (!stop && phase_next == pos_pkg::PH_WAIT && request_latch_next)
            phase_next = pos_pkg::PH_START;
          if (!stop && phase_next == pos_pkg::PH_START) begin
            if (!output_present) begin
              phase_next = pos_pkg::PH_END;
              stop       = 1'b1;
            end else begin
              logical_state_next = 1'b1;
              drive_level_next   = 1'b1;
              phase_next         = pos_pkg::PH_ARM;
            end
          end
          if (!stop && phase_next == pos_pkg::PH_ARM && !in_sense)
            phase_next = pos_pkg::PH_HIGH;
          if (!stop && phase_next == pos_pkg::PH_HIGH && in_sense) begin
            elapsed_next = '0;
            phase_next   = pos_pkg::PH_LOW;
          end
          if (!stop && phase_next == pos_pkg::PH_LOW &&
              timed_out(elapsed_next, sense_hold)) begin
            if (!output_present) begin
              phase_next = pos_pkg::PH_END;
              stop       = 1'b1;
            end else begin
              drive_level_next = 1'b0;
              phase_next       = pos_pkg::PH_DONE;
            end
          end
          if (!stop && phase_next == pos_pkg::PH_DONE) phase_next = pos_pkg::PH_END;
        end else begin
          // Normal mode: forced levels or one on/off pulse per request.
          if (phase_next == pos_pkg::PH_END) begin
            logical_state_next = 1'b0;
            if (output_present) drive_level_next = 1'b0;
            phase_next = pos_pkg::PH_IDLE;
          end
          if (on_time == pos_pkg::ON_TIME_W'(1)) begin
            logical_state_next = 1'b1;
            if (output_present) drive_level_next = 1'b1;
            on_event_next = 1'b1;
            stop          = 1'b1;
          end else if (on_time == '0) begin
            logical_state_next = 1'b0;
            if (output_present) drive_level_next = 1'b0;
            off_event_next = 1'b1;
            stop           = 1'b1;
          end
          // Leaving idle drops any pending request, including one made during a pulse.
          if (!stop && phase_next == pos_pkg::PH_IDLE) begin
            request_latch_next = 1'b0;
            phase_next         = pos_pkg::PH_WAIT;
          end
          if (!stop && phase_next == pos_pkg::PH_WAIT && request_latch_next)
            phase_next = pos_pkg::PH_START;
          if (!stop && phase_next == pos_pkg::PH_START) begin
            logical_state_next = 1'b1;
            if (output_present) drive_level_next = 1'b1;
            on_event_next = 1'b1;
            elapsed_next  = '0;
            phase_next    = pos_pkg::PH_ARM;
          end
          if (!stop && phase_next == pos_pkg::PH_ARM) begin
            elapsed_next = '0;
            phase_next   = pos_pkg::PH_HIGH;
          end
          if (!stop && phase_next == pos_pkg::PH_HIGH &&
              timed_out(elapsed_next, on_time)) begin
            logical_state_next = 1'b0;
            if (output_present) drive_level_next = 1'b0;
            off_event_next = 1'b1;
            elapsed_next   = '0;
            phase_next     = pos_pkg::PH_LOW;
          end
          if (!stop && phase_next == pos_pkg::PH_LOW &&
              timed_out(elapsed_next, on_time))
            phase_next = pos_pkg::PH_IDLE;
        end
      end
      pos_pkg::OP_REQUEST: begin
        request_latch_next = 1'b1;
      end
      pos_pkg::OP_SENSE: begin
        // Sense mode latches for good.
        sense_mode_next    = 1'b1;
        sense_hold_next    = in_delay;
        phase_next         = pos_pkg::PH_WAIT;
        request_latch_next = 1'b1;
      end
      default: begin
        logical_state_next = in_level;
        if (output_present) drive_level_next = in_level;
      end
    endcase
  end

  // Commit the step when the item advances into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= pos_pkg::PH_IDLE;
      request_latch <= 1'b0;
      sense_mode    <= 1'b0;
      sense_hold    <= '0;
      elapsed       <= '0;
      drive_level   <= 1'b0;
      logical_state <= 1'b0;
    end else if (advance) begin
      phase         <= phase_next;
      request_latch <= request_latch_next;
      sense_mode    <= sense_mode_next;
      sense_hold    <= sense_hold_next;
      elapsed       <= elapsed_next;
      drive_level   <= drive_level_next;
      logical_state <= logical_state_next;
    end
  end

  // Result register: load on advance, drop once transferred.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Pack the step's fields into the result word.
  always_comb begin
    result_word                        = '0;
    result_word[pos_pkg::OUT_PIN_BIT]   = drive_level_next ^ invert;
    result_word[pos_pkg::OUT_STATE_BIT] = logical_state_next;
    result_word[pos_pkg::OUT_ON_BIT]    = on_event_next;
    result_word[pos_pkg::OUT_OFF_BIT]   = off_event_next;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result_word;
    end
  end

endmodule

// ===== hw/rtl/pos_checker.sv =====
// Port-level checker for the pulse output sequencer, bound to the top level.
`timescale 1ns / 1ps
`include "pulse_output_sequencer_assert.svh"

module pos_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [pos_pkg::OUT_TDATA_W-1:0] m_tdata
);

  // A stalled result holds its value.
  `POS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  // A step never reports both a switch-on and a switch-off.
  `POS_ASSERT_SAME(a_events_excl, m_tvalid,
    !(m_tdata[pos_pkg::OUT_ON_BIT] && m_tdata[pos_pkg::OUT_OFF_BIT]))
  // Events agree with the reported state.
  `POS_ASSERT_SAME(a_on_state, m_tvalid && m_tdata[pos_pkg::OUT_ON_BIT],
    m_tdata[pos_pkg::OUT_STATE_BIT])
  `POS_ASSERT_SAME(a_off_state, m_tvalid && m_tdata[pos_pkg::OUT_OFF_BIT],
    !m_tdata[pos_pkg::OUT_STATE_BIT])
  // An empty result side never stalls the command side.
  `POS_ASSERT_SAME(a_ready_empty, !m_tvalid && !$past(m_tvalid), s_tready)

endmodule

bind pulse_output_sequencer pos_checker u_pos_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== tb/sv/pulse_output_sequencer_checker.sv =====
// Result checker for the pulse output sequencer: tracks the sequencer state and compares results.
`timescale 1ns / 1ps

module pulse_output_sequencer_checker
  import pos_pkg::*;
#(
  parameter int TIME_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   s_tvalid,
  input  logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [OPCODE_W-1:0]    s_tuser,
  input  logic                   m_tvalid,
  input  logic                   m_tready,
  input  logic [OUT_TDATA_W-1:0] m_tdata,
  output int                     errors,
  output int                     pending
);

  localparam longint unsigned TIMER_MAX = (64'd1 << TIME_BITS) - 1;

  typedef struct packed {
    logic pin;
    logic state;
    logic on_ev;
    logic off_ev;
  } pin_result_t;

  pin_result_t expected_pins[$];
  int unsigned results_seen;

  // Register copies
  logic [ON_TIME_W-1:0] on_time;
  logic                 invert;
  logic                 present;

  // Sequencer copy
  logic [2:0]           phase;
  logic                 req_latch;
  logic                 sense_mode;
  logic [DELAY_W-1:0]   hold_ticks;
  longint unsigned      elapsed;
  logic                 drive_lvl;
  logic                 logic_st;

  // A pin write is lost when no pin is attached.
  task automatic set_drive(input logic v);
    if (present) drive_lvl = v;
  endtask

  task automatic expired(input longint unsigned dur, output bit done);
    longint unsigned lim;
    lim  = (dur > TIMER_MAX) ? TIMER_MAX : dur;
    done = (elapsed >= lim);
  endtask

  task automatic sense_step(input logic sense);
    bit done;
    if (phase == PH_END) begin
      req_latch = 1'b0;
      logic_st  = 1'b0;
      phase     = PH_IDLE;
    end
    if (phase == PH_IDLE) phase = PH_WAIT;
    if (phase > PH_WAIT && !req_latch) begin
      phase = PH_END;
      return;
    end
    if (phase == PH_WAIT && req_latch) phase = PH_START;
    if (phase == PH_START) begin
      if (!present) begin
        phase = PH_END;
        return;
      end
      logic_st = 1'b1;
      set_drive(1'b1);
      phase = PH_ARM;
    end
    if (phase == PH_ARM && !sense) phase = PH_HIGH;
    if (phase == PH_HIGH && sense) begin
      elapsed = 0;
      phase   = PH_LOW;
    end
    if (phase == PH_LOW) begin
      expired(hold_ticks, done);
      if (done) begin
        if (!present) begin
          phase = PH_END;
          return;
        end
        set_drive(1'b0);
        phase = PH_DONE;
      end
    end
    if (phase == PH_DONE) phase = PH_END;
  endtask

  task automatic pulse_step(output logic on_ev, output logic off_ev);
    bit done;
    on_ev  = 1'b0;
    off_ev = 1'b0;
    if (phase == PH_END) begin
      logic_st = 1'b0;
      set_drive(1'b0);
      phase = PH_IDLE;
    end
    // on_time 1 and 0 force the output and notify on every tick
    if (on_time == 1) begin
      logic_st = 1'b1;
      set_drive(1'b1);
      on_ev = 1'b1;
      return;
    end
    if (on_time == 0) begin
      logic_st = 1'b0;
      set_drive(1'b0);
      off_ev = 1'b1;
      return;
    end
    // leaving idle drops any request made before
    if (phase == PH_IDLE) begin
      req_latch = 1'b0;
      phase     = PH_WAIT;
    end
    if (phase == PH_WAIT && req_latch) phase = PH_START;
    if (phase == PH_START) begin
      logic_st = 1'b1;
      set_drive(1'b1);
      on_ev   = 1'b1;
      elapsed = 0;
      phase   = PH_ARM;
    end
    if (phase == PH_ARM) begin
      elapsed = 0;
      phase   = PH_HIGH;
    end
    if (phase == PH_HIGH) begin
      expired(on_time, done);
      if (done) begin
        logic_st = 1'b0;
        set_drive(1'b0);
        off_ev  = 1'b1;
        elapsed = 0;
        phase   = PH_LOW;
      end
    end
    if (phase == PH_LOW) begin
      expired(on_time, done);
      if (done) phase = PH_IDLE;
    end
  endtask

  task automatic apply_command(input logic [OPCODE_W-1:0] op, input logic [IN_TDATA_W-1:0] data,
                               output pin_result_t r);
    logic on_ev, off_ev;
    on_ev  = 1'b0;
    off_ev = 1'b0;
    case (op)
      OP_TICK: begin
        if (elapsed < TIMER_MAX) elapsed++;
        if (sense_mode) sense_step(data[IN_SENSE_BIT]);
        else pulse_step(on_ev, off_ev);
      end
      OP_REQUEST: req_latch = 1'b1;
      OP_SENSE: begin
        sense_mode = 1'b1;
        hold_ticks = data[DELAY_W-1:0];
        phase      = PH_WAIT;
        req_latch  = 1'b1;
      end
      default: begin
        logic_st = data[IN_LEVEL_BIT];
        set_drive(data[IN_LEVEL_BIT]);
      end
    endcase
    r.pin    = drive_lvl ^ invert;
    r.state  = logic_st;
    r.on_ev  = on_ev;
    r.off_ev = off_ev;
  endtask

  always @(posedge clk) begin : watch
    pin_result_t got, want;
    if (rst) begin
      on_time      = '0;
      invert       = 1'b0;
      present      = 1'b1;
      phase        = PH_IDLE;
      req_latch    = 1'b0;
      sense_mode   = 1'b0;
      hold_ticks   = '0;
      elapsed      = 0;
      drive_lvl    = 1'b0;
      logic_st     = 1'b0;
      results_seen = 0;
      expected_pins.delete();
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          REG_ON_TIME:        on_time = cfg_data[ON_TIME_W-1:0];
          REG_INVERT:         invert  = cfg_data[0];
          REG_OUTPUT_PRESENT: present = cfg_data[0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got.pin    = m_tdata[OUT_PIN_BIT];
        got.state  = m_tdata[OUT_STATE_BIT];
        got.on_ev  = m_tdata[OUT_ON_BIT];
        got.off_ev = m_tdata[OUT_OFF_BIT];
        if (expected_pins.size() == 0) begin
          if (errors < 10) $display("%0t: result %b arrived with no command outstanding",
                                    $time, m_tdata);
          errors++;
        end else begin
          want = expected_pins.pop_front();
          if (got.pin !== want.pin || got.state !== want.state ||
              got.on_ev !== want.on_ev || got.off_ev !== want.off_ev) begin
            if (errors < 10)
              $display("%0t: result %0d pin %b/%b state %b/%b on %b/%b off %b/%b (exp/act)",
                       $time, results_seen, want.pin, got.pin, want.state, got.state,
                       want.on_ev, got.on_ev, want.off_ev, got.off_ev);
            errors++;
          end
        end
        results_seen++;
      end
      if (s_tvalid && s_tready) begin
        apply_command(s_tuser, s_tdata, want);
        expected_pins.push_back(want);
      end
    end
    pending = expected_pins.size();
  end

endmodule

// ===== tb/sv/pulse_output_sequencer_tb.sv =====
// Testbench top for the pulse output sequencer: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module pulse_output_sequencer_tb;
  import pos_pkg::*;

  localparam int TIME_BITS     = 16;
  // Cycles with no transfer on either side before the run is declared hung
  localparam int STALL_LIMIT   = 5000;
  // Pulse mode runs first: one sense command latches sense mode for good.
  localparam int NORMAL_PHASES = 10;
  localparam int NORMAL_ITEMS  = 100;
  localparam int SENSE_PHASES  = 6;
  localparam int SENSE_ITEMS   = 70;

  logic                   clk;
  logic                   rst;
  logic                   cfg_wr;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic [OPCODE_W-1:0]    s_tuser;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int                     errors;
  int                     pending;
  int                     idle_cycles;
  int                     sent;
  bit                     steady;       // no sender gaps while set
  logic [ON_TIME_W-1:0]   on_time_now;  // last on_time written

  pulse_output_sequencer #(
    .TIME_BITS(TIME_BITS)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pulse_output_sequencer_checker #(
    .TIME_BITS(TIME_BITS)
  ) result_check (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr   (cfg_wr),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result side: ready bursts of random length, sometimes very long ones,
  // broken up by stalls drawn from the same gap mix.
  initial begin : result_sink
    int unsigned run, stall;
    m_tready = 1'b1;
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      m_tready = 1'b1;
      repeat (run) @(negedge clk);
      stall = idle_len();
      if (stall != 0) begin
        m_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
    end
  end

  // Hang detection: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("pulse_output_sequencer_tb NOT OK");
      $finish;
    end
  end

  // Present one command after an optional gap and hold it until the transfer.
  // Called at a falling edge, returns at a falling edge with tvalid low.
  task automatic send_cmd(input logic [OPCODE_W-1:0] op, input logic [DELAY_W-1:0] delay,
                          input logic lvl, input logic sense);
    int unsigned gap;
    gap = steady ? 0 : idle_len();
    if (gap != 0) repeat (gap) @(negedge clk);
    s_tuser                 = op;
    s_tdata                 = '0;
    s_tdata[DELAY_W-1:0]    = delay;
    s_tdata[IN_LEVEL_BIT]   = lvl;
    s_tdata[IN_SENSE_BIT]   = sense;
    s_tvalid                = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    s_tvalid = 1'b0;
    sent++;
  endtask

  // A tick carries random filler in the fields it does not use.
  task automatic tick(input logic sense);
    send_cmd(OP_TICK, DELAY_W'($urandom), 1'($urandom), sense);
  endtask

  // Ticks, requests and level writes with random content; never a sense start.
  task automatic noise_item();
    logic [OPCODE_W-1:0] op;
    case ($urandom_range(0, 2))
      0:       op = OP_TICK;
      1:       op = OP_REQUEST;
      default: op = OP_LEVEL;
    endcase
    send_cmd(op, DELAY_W'($urandom), 1'($urandom), 1'($urandom));
  endtask

  // Drain every outstanding result, then let the pipeline settle before
  // touching the registers.
  task automatic settle();
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_index = idx;
    cfg_data  = val;
    cfg_wr    = 1'b1;
    @(negedge clk);
    cfg_wr    = 1'b0;
    if (idx == REG_ON_TIME) on_time_now = val[ON_TIME_W-1:0];
  endtask

  // Request, then enough ticks to see the on and off halves through to idle.
  // Long on-times get only a handful of ticks so the run stays short.
  task automatic pulse_run();
    int unsigned n;
    send_cmd(OP_REQUEST, DELAY_W'($urandom), 1'($urandom), 1'($urandom));
    n = (on_time_now < 16) ? 2 * on_time_now + $urandom_range(1, 5) : $urandom_range(4, 12);
    repeat (n) begin
      if ($urandom_range(0, 19) == 0) noise_item();
      else tick(1'($urandom));
    end
  endtask

  // Sense start (or a re-request), then the sense input high, low, high long
  // enough for a short hold to expire, then a few loose ticks.
  task automatic sense_cycle();
    logic [DELAY_W-1:0] hold;
    int unsigned        r;
    r = $urandom_range(0, 19);
    if (r == 0) hold = '1;
    else if (r == 1) hold = DELAY_W'($urandom);
    else hold = DELAY_W'($urandom_range(0, 5));
    if ($urandom_range(0, 3) == 0) send_cmd(OP_REQUEST, DELAY_W'($urandom), 1'($urandom), 1'b1);
    else send_cmd(OP_SENSE, hold, 1'($urandom), 1'($urandom));
    repeat ($urandom_range(0, 2)) tick(1'b1);
    repeat ($urandom_range(1, 3)) tick(1'b0);
    repeat (((hold < 8) ? hold : 6) + $urandom_range(1, 3)) tick(1'b1);
    repeat ($urandom_range(0, 2)) tick(1'($urandom));
  endtask

  initial begin : stimulus
    int                   ph;
    int                   target;
    logic [ON_TIME_W-1:0] ot;
    rst         = 1'b1;
    cfg_wr      = 1'b0;
    cfg_index   = REG_ON_TIME;
    cfg_data    = '0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = OP_TICK;
    steady      = 1'b0;
    sent        = 0;
    on_time_now = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: forced off with on_time 0, requests ignored while forced
    write_reg(REG_ON_TIME, 16'd0);
    write_reg(REG_INVERT, 16'd0);
    write_reg(REG_OUTPUT_PRESENT, 16'd1);
    send_cmd(OP_TICK, 16'h0000, 1'b0, 1'b0);
    send_cmd(OP_LEVEL, 16'hFFFF, 1'b1, 1'b1);
    send_cmd(OP_TICK, 16'hFFFF, 1'b1, 1'b1);
    send_cmd(OP_REQUEST, 16'h0000, 1'b0, 1'b0);
    tick(1'b0);

    // Forced on with on_time 1
    settle();
    write_reg(REG_ON_TIME, 16'd1);
    tick(1'b0);
    send_cmd(OP_LEVEL, 16'h5A5A, 1'b0, 1'b0);
    tick(1'b1);

    // One inverted pulse: the first request is dropped on leaving idle, the second starts it
    settle();
    write_reg(REG_ON_TIME, 16'd3);
    write_reg(REG_INVERT, 16'd1);
    send_cmd(OP_REQUEST, 16'hA5A5, 1'b1, 1'b0);
    repeat (4) tick(1'b0);
    send_cmd(OP_REQUEST, 16'h0000, 1'b0, 1'b0);
    send_cmd(OP_LEVEL, 16'hFFFF, 1'b0, 1'b1);
    repeat (4) tick(1'b1);

    // No pin attached: drive writes are lost, state still follows
    settle();
    write_reg(REG_OUTPUT_PRESENT, 16'd0);
    write_reg(REG_ON_TIME, 16'd2);
    send_cmd(OP_LEVEL, 16'h0000, 1'b1, 1'b0);
    send_cmd(OP_REQUEST, 16'hFFFF, 1'b0, 1'b1);
    repeat (3) tick(1'b0);

    // Pulse mode, random: mostly well-formed request-and-ticks runs
    for (ph = 0; ph < NORMAL_PHASES; ph++) begin
      settle();
      case (ph)
        0:       ot = 16'd2;
        1:       ot = 16'hFFFF;
        2:       ot = 16'd0;
        3:       ot = 16'd1;
        4:       ot = 16'hFFFE;
        5:       ot = 16'd3;
        default: ot = ON_TIME_W'($urandom_range(2, 9));
      endcase
      write_reg(REG_ON_TIME, ot);
      write_reg(REG_INVERT, CFG_DATA_W'(ph % 2));
      write_reg(REG_OUTPUT_PRESENT, (ph % 4 == 3) ? 16'd0 : 16'd1);
      steady = (ph % 3 == 1);
      target = sent + NORMAL_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 9) < 7) pulse_run();
        else noise_item();
      end
    end

    // Sense mode from here on: the first sense start latches it
    for (ph = 0; ph < SENSE_PHASES; ph++) begin
      settle();
      write_reg(REG_INVERT, CFG_DATA_W'(ph % 2));
      write_reg(REG_OUTPUT_PRESENT, (ph == 2 || ph == 4) ? 16'd0 : 16'd1);
      if (ph == 1) write_reg(REG_ON_TIME, CFG_DATA_W'($urandom));
      steady = (ph == 3);
      target = sent + SENSE_ITEMS;
      while (sent < target) begin
        if ($urandom_range(0, 3) != 0) sense_cycle();
        else noise_item();
      end
    end

    // Let the last results come out, then give the verdict
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("pulse_output_sequencer_tb OK");
    end else begin
      $display("pulse_output_sequencer_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== pulse_output_sequencer.f =====
+incdir+hw/rtl
hw/rtl/pos_pkg.sv
hw/rtl/pulse_output_sequencer.sv
hw/rtl/pos_checker.sv
tb/sv/pulse_output_sequencer_checker.sv
tb/sv/pulse_output_sequencer_tb.sv
